>>> rtl/core/csched_pkg.sv
package csched_pkg;

    // field widths
    localparam int TAG_W = 8;
    localparam int ARR_W = 16;
    localparam int BUR_W = 16;
    localparam int PRI_W = 8;
    localparam int OUT_W = 21;

    // output times saturate at the top of the 21-bit range
    localparam logic [OUT_W-1:0] TIME_SAT = {OUT_W{1'b1}};

    // round robin quantum after reset
    localparam logic [BUR_W-1:0] SLICE_RESET = 16'd25;

    // configuration register indexes
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SLICE  = 1'b1;

    typedef enum logic [1:0] {
        POL_FCFS = 2'd0,
        POL_PRIO = 2'd1,
        POL_SRTN = 2'd2,
        POL_RR   = 2'd3
    } t_policy;

    // one stored job descriptor
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] burst;
        logic [BUR_W-1:0] rem;
        logic [PRI_W-1:0] prio;
    } t_job;

    // controller to datapath
    typedef struct packed {
        logic wr_load;
        logic rd;
        logic first;
        logic decide;
        logic update;
        logic tat;
        logic emit;
        logic last;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic rescan;
        logic zero;
    } t_sts;

endpackage

>>> rtl/core/csched_ctrl.sv
module csched_ctrl import csched_pkg::*; #(
    parameter int MAX_JOBS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_last_job,
    input  t_sts                  i_sts,
    output t_cmd                  o_cmd,
    output logic [$clog2(MAX_JOBS)-1:0] o_addr,
    output logic                  o_busy
);

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_SWAIT  = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_TAT    = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_done, n_done;
    logic [AW-1:0]   r_sc, n_sc;
    logic            accept;
    logic            scan_end;
    logic            last_res;

    assign accept   = i_start && (r_state == S_IDLE);
    assign scan_end = (CW'(r_sc) + CW'(1)) == r_cnt;
    assign last_res = (r_done + CW'(1)) == r_cnt;
    assign o_busy   = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = r_done;
        n_sc    = r_sc;
        o_cmd   = '0;
        o_addr  = r_sc;
        unique case (r_state)
            S_IDLE: begin
                o_addr = r_cnt[AW-1:0];
                if (accept) begin
                    if (r_cnt < CW'(MAX_JOBS)) begin
                        o_cmd.wr_load = 1'b1;
                        n_cnt         = r_cnt + CW'(1);
                    end
                    if (i_last_job) begin
                        n_sc    = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd    = 1'b1;
                o_cmd.first = (r_sc == '0);
                if (scan_end) begin
                    n_state = S_SWAIT;
                end else begin
                    n_sc = r_sc + AW'(1);
                end
            end
            S_SWAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_sc         = '0;
                n_state      = i_sts.rescan ? S_SCAN : S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_sc         = '0;
                n_state      = i_sts.zero ? S_TAT : S_SCAN;
            end
            S_TAT: begin
                o_cmd.tat = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = last_res;
                n_sc       = '0;
                if (last_res) begin
                    o_cmd.clear = 1'b1;
                    n_cnt       = '0;
                    n_done      = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_done  = r_done + CW'(1);
                    n_state = S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= '0;
            r_sc    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            r_sc    <= n_sc;
        end
    end

    // a simulation always ends by going back to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && last_res) |=> (r_state == S_IDLE))
        else $error("final result did not return to idle");

    // completed jobs stay below the stored count while simulating
    a_done_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_done < r_cnt))
        else $error("done count reached job count while busy");

    // a simulation never starts on an empty set
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_job) |=> (r_cnt != '0))
        else $error("simulation started with no jobs");

endmodule

>>> rtl/core/csched_dp.sv
module csched_dp import csched_pkg::*; #(
    parameter int MAX_JOBS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [$clog2(MAX_JOBS)-1:0] i_addr,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [BUR_W-1:0]            i_cfg_data,
    input  logic [TAG_W-1:0]            i_job_id,
    input  logic [ARR_W-1:0]            i_arrival_time,
    input  logic [BUR_W-1:0]            i_burst_time,
    input  logic [PRI_W-1:0]            i_job_priority,
    output t_sts                        o_sts,
    output logic                        o_valid,
    output logic [TAG_W-1:0]            o_done_job_id,
    output logic [OUT_W-1:0]            o_completion_time,
    output logic [OUT_W-1:0]            o_turnaround_time,
    output logic [OUT_W-1:0]            o_waiting_time,
    output logic                        o_last_result
);

    localparam int AW = $clog2(MAX_JOBS);
    localparam int TW = ARR_W + $clog2(MAX_JOBS + 1);
    localparam int XW = (TW > OUT_W) ? TW : OUT_W;

    function automatic logic [OUT_W-1:0] sat(input logic [TW-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return (x > XW'(TIME_SAT)) ? TIME_SAT : x[OUT_W-1:0];
    endfunction

    // configuration
    t_policy          r_policy;
    logic [BUR_W-1:0] r_slice;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FCFS;
            r_slice  <= SLICE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POLICY: r_policy <= t_policy'(i_cfg_data[1:0]);
                REG_SLICE:  r_slice  <= i_cfg_data;
                default:    r_slice  <= r_slice;
            endcase
        end
    end

    // job store
    logic [$bits(t_job)-1:0] mem [MAX_JOBS];
    t_job             r_rd;
    logic             r_sv, r_sfirst;
    logic [AW-1:0]    r_sidx;
    logic [MAX_JOBS-1:0] r_fin;
    logic [TW-1:0]    r_time;

    // candidates of the current scan
    t_job             r_a, r_b, r_c;
    logic [AW-1:0]    r_a_idx, r_b_idx, r_c_idx;
    logic             r_a_v, r_b_v, r_c_v, r_n_v;
    logic [ARR_W-1:0] r_nxt;

    // round robin sweep position: last job run
    logic             r_sp_any;
    logic [ARR_W-1:0] r_last_arr;
    logic [AW-1:0]    r_last_idx;

    // job chosen for the current slice
    t_job             r_cur;
    logic [AW-1:0]    r_cur_idx;
    logic [BUR_W-1:0] r_run;
    logic [TW-1:0]    r_tat;

    t_job             wr_data;
    logic [AW-1:0]    wr_addr;
    logic [BUR_W-1:0] rem_new;

    assign rem_new = r_cur.rem - r_run;

    always_comb begin
        if (i_cmd.wr_load) begin
            wr_data.tag   = i_job_id;
            wr_data.arr   = i_arrival_time;
            wr_data.burst = i_burst_time;
            wr_data.rem   = i_burst_time;
            wr_data.prio  = i_job_priority;
            wr_addr       = i_addr;
        end else begin
            wr_data     = r_cur;
            wr_data.rem = rem_new;
            wr_addr     = r_cur_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_load || i_cmd.update) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd <= t_job'(mem[i_addr]);
        end
        r_sidx   <= i_addr;
        r_sfirst <= i_cmd.first;
    end

    // scan cell: compare one stored job against the running candidates
    t_job  d;
    logic  uf, arrived, later_last, a_better;
    logic  av, bv, cv, nv;
    logic  a_take, b_take, c_take, n_take;

    always_comb begin
        d          = r_rd;
        uf         = !r_fin[r_sidx];
        arrived    = TW'(d.arr) <= r_time;
        av         = r_a_v && !r_sfirst;
        bv         = r_b_v && !r_sfirst;
        cv         = r_c_v && !r_sfirst;
        nv         = r_n_v && !r_sfirst;
        later_last = (r_last_arr < d.arr) ||
                     (r_last_arr == d.arr && r_last_idx < r_sidx);
        case (r_policy)
            POL_PRIO: a_better = (d.prio > r_a.prio) ||
                                 (d.prio == r_a.prio && d.arr < r_a.arr);
            POL_SRTN: a_better = (d.rem < r_a.rem) ||
                                 (d.rem == r_a.rem && d.arr < r_a.arr);
            default:  a_better = d.arr < r_a.arr;
        endcase
        a_take = uf && arrived && (r_policy != POL_RR || r_sp_any || later_last) &&
                 (!av || a_better);
        b_take = uf && arrived && (!bv || d.arr < r_b.arr);
        c_take = uf && (!cv || d.arr < r_c.arr);
        n_take = uf && !arrived && (!nv || d.arr < r_nxt);
    end

    // decision after a full scan
    t_job             sel;
    logic [AW-1:0]    sel_idx;
    logic [BUR_W-1:0] run;
    logic [BUR_W-1:0] q;
    logic [TW-1:0]    time_n;
    logic [TW-1:0]    gap;

    assign q   = (r_slice == '0) ? BUR_W'(1) : r_slice;
    assign gap = TW'(r_nxt) - r_time;

    always_comb begin
        sel     = r_c;
        sel_idx = r_c_idx;
        run     = r_c.rem;
        time_n  = r_time;
        case (r_policy) inside
            POL_FCFS: begin
                if (TW'(r_c.arr) > r_time) begin
                    time_n = TW'(r_c.arr);
                end
            end
            POL_PRIO, POL_SRTN: begin
                if (r_a_v) begin
                    sel     = r_a;
                    sel_idx = r_a_idx;
                    run     = r_a.rem;
                    if (r_policy == POL_SRTN && r_n_v && gap < TW'(r_a.rem)) begin
                        run = gap[BUR_W-1:0];
                    end
                end else begin
                    time_n = TW'(r_c.arr);
                end
            end
            default: begin
                if (r_a_v) begin
                    sel     = r_a;
                    sel_idx = r_a_idx;
                end else if (r_b_v) begin
                    sel     = r_b;
                    sel_idx = r_b_idx;
                end else begin
                    time_n = TW'(r_c.arr);
                end
                run = (sel.rem < q) ? sel.rem : q;
            end
        endcase
    end

    assign o_sts.rescan = (r_policy == POL_PRIO || r_policy == POL_SRTN) && !r_a_v;
    assign o_sts.zero   = (rem_new == '0);

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv     <= 1'b0;
            r_fin    <= '0;
            r_time   <= '0;
            r_sp_any <= 1'b1;
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_c_v    <= 1'b0;
            r_n_v    <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_sv    <= i_cmd.rd;
            o_valid <= i_cmd.emit;
            if (r_sv) begin
                r_a_v <= a_take || av;
                r_b_v <= b_take || bv;
                r_c_v <= c_take || cv;
                r_n_v <= n_take || nv;
            end
            if (i_cmd.decide) begin
                r_time <= time_n;
                if (r_policy == POL_RR) begin
                    r_sp_any <= 1'b0;
                end
            end
            if (i_cmd.update) begin
                r_time <= r_time + TW'(r_run);
                if (rem_new == '0) begin
                    r_fin[r_cur_idx] <= 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_fin    <= '0;
                r_time   <= '0;
                r_sp_any <= 1'b1;
            end
        end
    end

    // candidate payload, chosen job and result registers
    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (a_take) begin
                r_a     <= d;
                r_a_idx <= r_sidx;
            end
            if (b_take) begin
                r_b     <= d;
                r_b_idx <= r_sidx;
            end
            if (c_take) begin
                r_c     <= d;
                r_c_idx <= r_sidx;
            end
            if (n_take) begin
                r_nxt <= d.arr;
            end
        end
        if (i_cmd.decide) begin
            r_cur     <= sel;
            r_cur_idx <= sel_idx;
            r_run     <= run;
            if (r_policy == POL_RR) begin
                r_last_arr <= sel.arr;
                r_last_idx <= sel_idx;
            end
        end
        if (i_cmd.tat) begin
            r_tat <= r_time - TW'(r_cur.arr);
        end
        if (i_cmd.emit) begin
            o_done_job_id     <= r_cur.tag;
            o_completion_time <= sat(r_time);
            o_turnaround_time <= sat(r_tat);
            o_waiting_time    <= sat(r_tat - TW'(r_cur.burst));
            o_last_result     <= i_cmd.last;
        end
    end

endmodule

>>> rtl/core/cpu_schedule_simulator.sv
// CPU schedule simulator. Jobs are loaded one per start transaction (one
// cycle each) while busy is low; the job marked last launches a simulation of
// the stored set under the configured policy, and busy stays high until the
// final result. Each scheduling decision scans every stored job through the
// single read port of the job store, so each time slice runs a scan, a read
// wait, a decide and an update step, plus a turnaround and a result step when
// the slice completes a job; policies 1 and 2 add a further scan each time the
// CPU idles forward. Under policies 0 and 1 each job runs to completion in its
// first slice; shortest remaining time adds a slice at each preemption and
// round robin one per quantum. Results come one per strobe on o_valid and
// cannot be held off: the receiver must take each in the cycle it appears.
module cpu_schedule_simulator import csched_pkg::*; #(
    parameter int MAX_JOBS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [TAG_W-1:0] i_job_id,
    input  logic [ARR_W-1:0] i_arrival_time,
    input  logic [BUR_W-1:0] i_burst_time,
    input  logic [PRI_W-1:0] i_job_priority,
    input  logic             i_last_job,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [BUR_W-1:0] i_cfg_data,
    output logic             o_valid,
    output logic [TAG_W-1:0] o_done_job_id,
    output logic [OUT_W-1:0] o_completion_time,
    output logic [OUT_W-1:0] o_turnaround_time,
    output logic [OUT_W-1:0] o_waiting_time,
    output logic             o_last_result
);

    localparam int AW = $clog2(MAX_JOBS);

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] addr;

    csched_ctrl #(.MAX_JOBS(MAX_JOBS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_last_job (i_last_job),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_addr     (addr),
        .o_busy     (o_busy)
    );

    csched_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_addr            (addr),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_job_id          (i_job_id),
        .i_arrival_time    (i_arrival_time),
        .i_burst_time      (i_burst_time),
        .i_job_priority    (i_job_priority),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .o_done_job_id     (o_done_job_id),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_last_result     (o_last_result)
    );

endmodule
